@@ design/iopb_pkg.sv @@
package iopb_pkg;

  localparam int unsigned BITMAP_WORDS = 2048;
  localparam int unsigned WORD_BITS    = 32;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned OFF_W      = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned IDX_FULL_W = PORT_W - OFF_W;
  localparam int unsigned END_W      = COUNT_W + 1;
  localparam int unsigned LIMIT      = BITMAP_WORDS * WORD_BITS;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_GRANT  = 2'd0,
    OP_REVOKE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_GRANT,
    KIND_REVOKE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              err;
    logic [WIDX_W-1:0] w0;
    logic [WIDX_W-1:0] w1;
    logic [OFF_W-1:0]  lo_off;
    logic [OFF_W-1:0]  hi_off;
  } cmd_t;

endpackage

@@ design/iopb_req_if.sv @@
interface iopb_req_if import iopb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [PORT_W-1:0]  first_port;
  logic [COUNT_W-1:0] port_count;

  modport source(output valid, output operation, output first_port, output port_count,
                 input ready);
  modport sink(input valid, input operation, input first_port, input port_count,
               output ready);
endinterface

@@ design/iopb_rsp_if.sv @@
interface iopb_rsp_if import iopb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] read_word;
  logic                 range_error;

  modport source(output valid, output read_word, output range_error, input ready);
  modport sink(input valid, input read_word, input range_error, output ready);
endinterface

@@ design/iopb_front.sv @@
module iopb_front import iopb_pkg::*; (
  iopb_req_if.sink req_i,
  input  logic     clearing_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic [END_W-1:0]      first_ext;
  logic [END_W-1:0]      run_end;
  logic [END_W-1:0]      end_clip;
  logic [END_W-1:0]      end_m1;
  logic [END_W-1:0]      limit_ext;
  logic [IDX_FULL_W-1:0] idx_full;
  logic                  zero_len;
  logic                  start_out;
  logic                  clipped;
  logic                  rd_out;

  assign req_i.ready = !full_i && !clearing_i;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    first_ext = {{(END_W-PORT_W){1'b0}}, req_i.first_port};
    limit_ext = END_W'(LIMIT);
    run_end   = first_ext + {{(END_W-COUNT_W){1'b0}}, req_i.port_count};
    zero_len  = (req_i.port_count == '0);
    start_out = (first_ext >= limit_ext);
    clipped   = (run_end > limit_ext);
    end_clip  = clipped ? limit_ext : run_end;
    end_m1    = end_clip - END_W'(1);
    idx_full  = req_i.first_port[PORT_W-1:OFF_W];
    rd_out    = ({1'b0, idx_full} >= (IDX_FULL_W+1)'(BITMAP_WORDS));

    cmd_o.kind   = KIND_NONE;
    cmd_o.err    = 1'b0;
    cmd_o.w0     = req_i.first_port[OFF_W +: WIDX_W];
    cmd_o.w1     = end_m1[OFF_W +: WIDX_W];
    cmd_o.lo_off = req_i.first_port[OFF_W-1:0];
    cmd_o.hi_off = end_clip[OFF_W-1:0];

    case (req_i.operation)
      OP_GRANT, OP_REVOKE: begin
        if (zero_len || start_out) begin
          cmd_o.err = 1'b1;
        end else begin
          cmd_o.kind = (req_i.operation == OP_GRANT) ? KIND_GRANT : KIND_REVOKE;
          cmd_o.err  = clipped;
        end
      end
      OP_READ: begin
        if (rd_out) begin
          cmd_o.err = 1'b1;
        end else begin
          cmd_o.kind = KIND_READ;
        end
      end
      default: begin
        cmd_o.kind = KIND_NONE;
      end
    endcase
  end

endmodule

@@ design/iopb_cmd_queue.sv @@
module iopb_cmd_queue import iopb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ design/iopb_back.sv @@
module iopb_back import iopb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       clearing_o,
  iopb_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_MOD,
    ST_RESP
  } state_e;

  state_e               state_q, state_d;
  cmd_t                 cur_q, cur_d;
  logic [WIDX_W-1:0]    w_q, w_d;
  logic [WIDX_W-1:0]    clr_q, clr_d;
  logic [WORD_BITS-1:0] res_word_q, res_word_d;
  logic                 res_err_q, res_err_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [WORD_BITS-1:0] rsp_word_q, rsp_word_d;
  logic                 rsp_err_q, rsp_err_d;

  logic [WORD_BITS-1:0] permit_bitmap_q [BITMAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [WIDX_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, mask;

  assign clearing_o        = (state_q == ST_CLEAR);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_word   = rsp_word_q;
  assign rsp_o.range_error = rsp_err_q;

  // partial masks for the first and last words of the run
  always_comb begin
    lo_mask = (w_q == cur_q.w0) ? (ALL_ONES << cur_q.lo_off) : ALL_ONES;
    hi_mask = ((w_q == cur_q.w1) && (cur_q.hi_off != '0)) ? ~(ALL_ONES << cur_q.hi_off)
                                                          : ALL_ONES;
    mask    = lo_mask & hi_mask;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    w_d         = w_q;
    clr_d       = clr_q;
    res_word_d  = res_word_q;
    res_err_d   = res_err_q;
    rsp_valid_d = rsp_valid_q;
    rsp_word_d  = rsp_word_q;
    rsp_err_d   = rsp_err_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = w_q;
    mem_raddr   = w_q;
    mem_wdata   = ALL_ONES;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + WIDX_W'(1);
        if (clr_q == WIDX_W'(BITMAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          cur_d      = head_i;
          w_d        = head_i.w0;
          res_word_d = '0;
          res_err_d  = head_i.err;
          case (head_i.kind)
            KIND_READ: begin
              mem_re    = 1'b1;
              mem_raddr = head_i.w0;
              state_d   = ST_RDWAIT;
            end
            KIND_GRANT, KIND_REVOKE: begin
              mem_re    = 1'b1;
              mem_raddr = head_i.w0;
              state_d   = ST_MOD;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        res_word_d = rdata_q;
        state_d    = ST_RESP;
      end
      ST_MOD: begin
        // write back this word while fetching the next one
        mem_we    = 1'b1;
        mem_waddr = w_q;
        mem_wdata = (cur_q.kind == KIND_GRANT) ? (rdata_q & ~mask) : (rdata_q | mask);
        if (w_q == cur_q.w1) begin
          state_d = ST_RESP;
        end else begin
          w_d       = w_q + WIDX_W'(1);
          mem_re    = 1'b1;
          mem_raddr = w_q + WIDX_W'(1);
        end
      end
      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_word_d  = res_word_q;
          rsp_err_d   = res_err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    w_q        <= w_d;
    res_word_q <= res_word_d;
    res_err_q  <= res_err_d;
    rsp_word_q <= rsp_word_d;
    rsp_err_q  <= rsp_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      permit_bitmap_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= permit_bitmap_q[mem_raddr];
    end
  end

endmodule

@@ design/io_permit_bitmap_range_update.sv @@
// the back end pops a command and reads the first word; a read returns that word,
// a grant or revoke rewrites the run word by word, and a rejected or unused
// operation goes straight to the response (one read-modify-write of the bitmap memory
// per cycle through its single write port); the back end serves one command at a time
// a two-entry command queue lets new requests in while the back end walks a run
// after reset all 2048 bitmap words are filled with ones, requests held off meanwhile
module io_permit_bitmap_range_update import iopb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  iopb_req_if.sink   req_i,
  iopb_rsp_if.source rsp_o
);

  logic clearing;
  logic full;
  logic empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  iopb_front u_front (
    .req_i      (req_i),
    .clearing_i (clearing),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  iopb_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  iopb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .rsp_o      (rsp_o)
  );

endmodule
